/* src/dtfi_pkg.sv */
// package: shared types and constants for the double to float interval block
`default_nettype none
package dtfi_pkg;
    localparam logic [62:0] MagInf64  = 63'h7FF0000000000000;
    localparam logic [62:0] MagFmax64 = 63'h47EFFFFFE0000000;
    localparam logic [31:0] FmaxBits  = 32'h7F7FFFFF;
    localparam logic [31:0] Inf32Bits = 32'h7F800000;

    // classification of the input magnitude
    typedef enum logic [1:0] {
        t_cls_fin  = 2'd0,
        t_cls_big  = 2'd1,
        t_cls_nan  = 2'd2
    } t_cls;

    typedef struct packed {
        logic        neg;
        t_cls        cls;
        logic [21:0] nan_pay;
    } t_side;
endpackage
`default_nettype wire

/* src/dtfi_if.sv */
// interfaces: valid/ready channels for the input and result beats
`default_nettype none
interface dtfi_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    modport source(output valid, output value_bits, input ready);
    modport sink(input valid, input value_bits, output ready);
endinterface

interface dtfi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] lower_bits;
    logic [31:0] upper_bits;
    modport source(output valid, output lower_bits, output upper_bits, input ready);
    modport sink(input valid, input lower_bits, input upper_bits, output ready);
endinterface
`default_nettype wire

/* src/double_to_float_interval.sv */
// top level: binary64 to binary32 directed rounding interval converter
// an accepted input beat passes through stage registers r1, r2 and r3 to its result beat
// throughput: one beat per cycle; the three-stage pipeline advances whenever
// the result register is empty or being taken
// a stall holds every stage; no beat is dropped or repeated
// reset: synchronous active-low i_rst_n clears all valid bits
`default_nettype none
module double_to_float_interval (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtfi_in_if.sink   i_in,
    dtfi_out_if.source o_out
);
    // pipeline moves when its last stage is empty or the sink takes it
    logic            en;
    logic [62:0]     mag;
    dtfi_pkg::t_side side;

    assign en       = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // classify up front so the special-case info rides beside the datapath
    always_comb begin
        mag          = i_in.value_bits[62:0];
        side.neg     = i_in.value_bits[63];
        side.nan_pay = mag[50:29];
        if (mag > dtfi_pkg::MagInf64)       side.cls = dtfi_pkg::t_cls_nan;
        else if (mag > dtfi_pkg::MagFmax64) side.cls = dtfi_pkg::t_cls_big;
        else                                side.cls = dtfi_pkg::t_cls_fin;
    end

    dtfi_trunc u_trunc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_mag   (mag),
        .i_side  (side),
        .o_valid (o_out.valid),
        .o_lower (o_out.lower_bits),
        .o_upper (o_out.upper_bits)
    );

    // a stalled result keeps its payload until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.lower_bits))
        else $error("result changed under stall");
    // input is taken whenever the output is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("pipeline stalled with empty output");
    // an empty pipeline after reset emits nothing
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

/* src/dtfi_trunc.sv */
// truncation datapath: binary64 magnitude to binary32 magnitude, three stages
`default_nettype none
module dtfi_trunc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [62:0] i_mag,
    input  wire dtfi_pkg::t_side i_side,
    output logic             o_valid,
    output logic [31:0]      o_lower,
    output logic [31:0]      o_upper
);
    // stage 1: register the sign and class, split exponent and mantissa
    logic            r1_v, r2_v, r3_v;
    dtfi_pkg::t_side r1_side, r2_side;
    logic [10:0]     r1_e;
    logic [51:0]     r1_m;
    logic [31:0]     r2_t;
    logic            r2_lost;
    logic [31:0]     r3_lo, r3_hi;

    logic [10:0] n_sh;
    logic [52:0] sig;
    logic [116:0] wide;
    logic [31:0] n_t;
    logic        n_lost;
    logic [31:0] away;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_side;
            r1_e    <= i_mag[62:52];
            r1_m    <= i_mag[51:0];
        end
    end

    // stage 2: truncate and detect discarded bits
    always_comb begin
        sig    = {1'b1, r1_m};
        n_sh   = 11'd926 - r1_e;
        wide   = {sig, 64'd0} >> n_sh[6:0];
        n_t    = 32'd0;
        n_lost = 1'b0;
        if (r1_e == 11'd0) begin
            n_lost = (r1_m != 52'd0);
        end else if (r1_e > 11'd896) begin
            n_t    = {1'b0, 8'(r1_e - 11'd896), r1_m[51:29]};
            n_lost = (r1_m[28:0] != 29'd0);
        end else if (n_sh >= 11'd64) begin
            n_lost = 1'b1;
        end else begin
            n_t    = wide[95:64];
            n_lost = (wide[63:0] != 64'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= r1_side;
            r2_t    <= n_t;
            r2_lost <= n_lost;
        end
    end

    // stage 3: increment away from zero and resolve special cases
    assign away = r2_t + {31'd0, r2_lost};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r2_side.cls)
                dtfi_pkg::t_cls_nan: begin
                    r3_lo <= {r2_side.neg, 9'h1FF, r2_side.nan_pay};
                    r3_hi <= {r2_side.neg, 9'h1FF, r2_side.nan_pay};
                end
                dtfi_pkg::t_cls_big: begin
                    r3_lo <= r2_side.neg ? {1'b1, dtfi_pkg::Inf32Bits[30:0]}
                                         : dtfi_pkg::FmaxBits;
                    r3_hi <= r2_side.neg ? {1'b1, dtfi_pkg::FmaxBits[30:0]}
                                         : dtfi_pkg::Inf32Bits;
                end
                default: begin
                    r3_lo <= r2_side.neg ? (away | 32'h80000000) : r2_t;
                    r3_hi <= r2_side.neg ? (r2_t | 32'h80000000) : away;
                end
            endcase
        end
    end

    assign o_valid = r3_v;
    assign o_lower = r3_lo;
    assign o_upper = r3_hi;
endmodule
`default_nettype wire
